### rtl/lse_pkg.sv
// Shared types, constants and helpers for the LSB stego extractor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lse_pkg;

	// Identifier length in bytes and config register layout
	localparam int IDENT_LEN   = 12;
	localparam int HALF_IDENT  = 6;
	localparam int CFG_W       = 48;
	localparam int CFG_ADDR_W  = 1;

	localparam logic [CFG_ADDR_W-1:0] REG_IDENT_FIRST = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_IDENT_LAST  = 1'b1;

	localparam logic [CFG_W-1:0] IDENT_FIRST_RST = 48'd84947900784965;
	localparam logic [CFG_W-1:0] IDENT_LAST_RST  = 48'd122489874445136;

	// Parser phases
	localparam logic [2:0] PH_IDENT   = 3'd0;
	localparam logic [2:0] PH_NAMELEN = 3'd1;
	localparam logic [2:0] PH_NAME    = 3'd2;
	localparam logic [2:0] PH_SIZE    = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_IDLE    = 3'd5;

	// Result kinds and status codes
	localparam logic [1:0] KIND_NAME    = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_STATUS  = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISMATCH = 2'd1;
	localparam logic [1:0] ST_NO_DATA  = 2'd2;

	// One captured pixel: gathered LSB nibble and image start flag
	typedef struct packed {
		logic [3:0] nib;
		logic       first;
	} lse_beat_t;

	// Expected identifier byte k (k below IDENT_LEN)
	function automatic logic [7:0] ident_byte(input logic [CFG_W-1:0] first_six,
		input logic [CFG_W-1:0] last_six, input logic [3:0] k);
		logic [7:0] r;
		r = 8'd0;
		for (int i = 0; i < HALF_IDENT; i++) begin
			if (k == 4'(i))
				r = first_six[8*i +: 8];
			if (k == 4'(i + HALF_IDENT))
				r = last_six[8*i +: 8];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/lse_capture.sv
// Input register: gathers the four channel LSBs of a pixel beat.
// Depends on lse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lse_capture import lse_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // red, green, blue, alpha
	input  wire logic        s_tuser,   // first_pixel
	output logic             beat_valid_s1,
	output lse_beat_t        beat_s1,
	input  wire logic        beat_ready
);

	// Stage takes a new beat when empty or draining this cycle
	assign s_tready = !beat_valid_s1 || beat_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			beat_valid_s1 <= s_tvalid;
		end
	end

	// Payload: LSB gather, no reset needed
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			beat_s1.nib   <= {s_tdata[24], s_tdata[16], s_tdata[8], s_tdata[0]};
			beat_s1.first <= s_tuser;
		end
	end

endmodule

`default_nettype wire

### rtl/lse_parser.sv
// Byte assembly, header parser, identifier registers and result register.
// Depends on lse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lse_parser import lse_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_W-1:0]      cfg_wdata,
	input  wire logic                  beat_valid_s1,
	input  wire lse_beat_t             beat_s1,
	output logic                       beat_ready,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [7:0]                 m_tdata,   // result_byte
	output logic [3:0]                 m_tuser,   // kind, status
	output logic                       m_tlast    // last
);

	logic [CFG_W-1:0] ident_first_q, ident_last_q;
	logic [2:0]  phase_q;
	logic        second_half_q, ident_match_q;
	logic [3:0]  low_nibble_q;
	logic [31:0] field_count_q, payload_size_q;
	logic [15:0] name_length_q;

	logic [2:0]  ph, ph_n;
	logic        sh, sh_n, im, im_n;
	logic [3:0]  lo_n;
	logic [31:0] fc, fc_n, fc_inc, ps, ps_n;
	logic [15:0] nl, nl_n;
	logic [7:0]  b;
	logic        res_v, res_last;
	logic [7:0]  res_byte;
	logic [1:0]  res_kind, res_status;
	logic        take;

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ident_first_q <= IDENT_FIRST_RST;
			ident_last_q  <= IDENT_LAST_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_IDENT_FIRST: ident_first_q <= cfg_wdata;
				REG_IDENT_LAST:  ident_last_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Result register frees up when empty or taken
	assign beat_ready = !m_tvalid || m_tready;
	assign take       = beat_valid_s1 && beat_ready;

	// Next-state and result logic; a first-pixel mark restarts parsing first
	always_comb begin
		ph = beat_s1.first ? PH_IDENT : phase_q;
		sh = beat_s1.first ? 1'b0 : second_half_q;
		fc = beat_s1.first ? 32'd0 : field_count_q;
		nl = beat_s1.first ? 16'd0 : name_length_q;
		ps = beat_s1.first ? 32'd0 : payload_size_q;
		im = beat_s1.first ? 1'b1 : ident_match_q;

		ph_n = ph; sh_n = sh; fc_n = fc; nl_n = nl; ps_n = ps; im_n = im;
		lo_n = low_nibble_q;
		fc_inc = fc + 32'd1;
		b = {beat_s1.nib, low_nibble_q};
		res_v = 1'b0; res_byte = 8'd0; res_kind = KIND_STATUS;
		res_status = ST_OK; res_last = 1'b0;

		if (ph != PH_IDLE) begin
			if (!sh) begin
				lo_n = beat_s1.nib;
				sh_n = 1'b1;
			end else begin
				sh_n = 1'b0;
				unique case (ph)
					PH_IDENT: begin
						im_n = im && (b == ident_byte(ident_first_q, ident_last_q, fc[3:0]));
						if (fc_inc >= 32'(IDENT_LEN)) begin
							fc_n = 32'd0;
							if (!im_n) begin
								ph_n = PH_IDLE;
								res_v = 1'b1; res_status = ST_MISMATCH; res_last = 1'b1;
							end else begin
								ph_n = PH_NAMELEN;
							end
						end else begin
							fc_n = fc_inc;
						end
					end
					PH_NAMELEN: begin
						if (fc == 32'd0) begin
							nl_n = {8'd0, b};
							fc_n = 32'd1;
						end else begin
							nl_n = {b, nl[7:0]};
							fc_n = 32'd0;
							if (nl_n == 16'd0) begin
								ph_n = PH_IDLE;
								res_v = 1'b1; res_status = ST_NO_DATA; res_last = 1'b1;
							end else begin
								ph_n = PH_NAME;
							end
						end
					end
					PH_NAME: begin
						if (fc_inc >= {16'd0, nl}) begin
							fc_n = 32'd0;
							ph_n = PH_SIZE;
						end else begin
							fc_n = fc_inc;
						end
						res_v = 1'b1; res_byte = b; res_kind = KIND_NAME;
					end
					PH_SIZE: begin
						ps_n[8*fc[1:0] +: 8] = ps[8*fc[1:0] +: 8] | b;
						if (fc_inc >= 32'd4) begin
							fc_n = 32'd0;
							if (ps_n == 32'd0) begin
								ph_n = PH_IDLE;
								res_v = 1'b1; res_status = ST_NO_DATA; res_last = 1'b1;
							end else begin
								ph_n = PH_PAYLOAD;
							end
						end else begin
							fc_n = fc_inc;
						end
					end
					PH_PAYLOAD: begin
						fc_n = fc_inc;
						res_v = 1'b1; res_byte = b; res_kind = KIND_PAYLOAD;
						if (fc_inc >= ps) begin
							ph_n = PH_IDLE;
							res_last = 1'b1;
						end
					end
					default: ph_n = PH_IDLE;
				endcase
			end
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDENT;
			second_half_q  <= 1'b0;
			low_nibble_q   <= 4'd0;
			field_count_q  <= 32'd0;
			name_length_q  <= 16'd0;
			payload_size_q <= 32'd0;
			ident_match_q  <= 1'b1;
		end else if (take) begin
			phase_q        <= ph_n;
			second_half_q  <= sh_n;
			low_nibble_q   <= lo_n;
			field_count_q  <= fc_n;
			name_length_q  <= nl_n;
			payload_size_q <= ps_n;
			ident_match_q  <= im_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (beat_ready) begin
			m_tvalid <= take && res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_v) begin
			m_tdata <= res_byte;
			m_tuser <= {res_status, res_kind};
			m_tlast <= res_last;
		end
	end

endmodule

`default_nettype wire

### rtl/lsb_stego_extractor_core.sv
// Top level of the LSB stego extractor: pixel capture stage and parser.
// Depends on lse_pkg, lse_capture, lse_parser.
//
//  channel  | dir | beat contents
//  ---------+-----+-------------------------------------------------------
//  s_*      | in  | tdata red,green,blue,alpha; tuser first_pixel
//  m_*      | out | tdata result_byte; tuser kind,status; tlast last
//  cfg_*    | in  | cfg_addr 0 ident bytes 0..5, 1 ident bytes 6..11
//
// One pixel per clock sustained while the m side does not stall; an s beat
// passes through the capture register, then the parser and result register.
// Reset clears parser state and loads the default identifier.
// A stalled m side holds the result; the capture stage keeps taking
// pixels until it is full too.
`timescale 1ns / 1ps
`default_nettype none

module lsb_stego_extractor_core import lse_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_W-1:0]      cfg_wdata,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [31:0]           s_tdata,   // red, green, blue, alpha
	input  wire logic                  s_tuser,   // first_pixel
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [7:0]                 m_tdata,   // result_byte
	output logic [3:0]                 m_tuser,   // kind, status
	output logic                       m_tlast    // last
);

	logic      beat_valid_s1, beat_ready;
	lse_beat_t beat_s1;

	lse_capture u_capture (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.beat_valid_s1, .beat_s1, .beat_ready
	);

	lse_parser u_parser (
		.clk, .arst_n, .cfg_we, .cfg_addr, .cfg_wdata,
		.beat_valid_s1, .beat_s1, .beat_ready,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
	);

endmodule

`default_nettype wire
